// File: hw/rtl/sse_pkg.sv
// ----------------------------------------------------------------------------
// Searchable stack engine package
// Shared widths, operation and status codes, and the control word that drives
// each storage cell of the chain.
// ----------------------------------------------------------------------------
package sse_pkg;

   localparam int WORD_W    = 32;
   localparam int OP_W      = 3;
   localparam int POS_W     = 6;
   localparam int FILL_W    = 7;
   localparam int STATUS_W  = 3;
   localparam int DEPTH_DEF = 64;

   localparam logic [OP_W-1:0] OP_PUSH    = 3'd0;
   localparam logic [OP_W-1:0] OP_POP     = 3'd1;
   localparam logic [OP_W-1:0] OP_SEARCH  = 3'd2;
   localparam logic [OP_W-1:0] OP_REPLACE = 3'd3;
   localparam logic [OP_W-1:0] OP_WRITE   = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd4;

   // Move toward higher cell index, move toward cell 0, or overwrite.
   typedef struct packed {
      logic shift_dn;
      logic shift_up;
      logic wr_en;
   } cell_ctrl_type;

endpackage

// File: hw/rtl/sse_cell.sv
// ----------------------------------------------------------------------------
// Stack cell
// Holds one stored word and takes a new one from either neighbor or from the
// write bus, as the control word says.
// ----------------------------------------------------------------------------
module sse_cell (
   input  logic                          clock,
   input  sse_pkg::cell_ctrl_type        ctrl,
   input  logic [sse_pkg::WORD_W-1:0]    prev_word,
   input  logic [sse_pkg::WORD_W-1:0]    next_word,
   input  logic [sse_pkg::WORD_W-1:0]    wr_word,
   output logic [sse_pkg::WORD_W-1:0]    word
);
   import sse_pkg::*;

   logic [WORD_W-1:0] data_ff;
   logic [WORD_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.wr_en) begin
         data_in = wr_word;
      end else if (ctrl.shift_dn) begin
         data_in = prev_word;
      end else if (ctrl.shift_up) begin
         data_in = next_word;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign word = data_ff;

endmodule

// File: hw/rtl/sse_ctrl.sv
// ----------------------------------------------------------------------------
// Stack controller
// Decodes operations, keeps the fill level, steers the cell chain, walks the
// chain for search and replace-all, and holds the result register.
// ----------------------------------------------------------------------------
module sse_ctrl #(
   parameter int DEPTH = sse_pkg::DEPTH_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic [sse_pkg::OP_W-1:0]                 req_operation,
   input  logic signed [sse_pkg::WORD_W-1:0]        req_value,
   input  logic signed [sse_pkg::WORD_W-1:0]        req_new_value,
   input  logic [sse_pkg::POS_W-1:0]                req_position,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic [sse_pkg::STATUS_W-1:0]             rsp_status,
   output logic signed [sse_pkg::WORD_W-1:0]        rsp_popped_word,
   output logic [sse_pkg::POS_W-1:0]                rsp_match_position,
   output logic [sse_pkg::FILL_W-1:0]               rsp_fill_level,
   output logic                                     rsp_last,
   output sse_pkg::cell_ctrl_type                   cmd,
   output logic [$clog2(DEPTH)-1:0]                 wr_idx,
   output logic [sse_pkg::WORD_W-1:0]               wr_word,
   output logic [sse_pkg::WORD_W-1:0]               head_in,
   input  logic [sse_pkg::WORD_W-1:0]               head_word,
   input  logic [sse_pkg::WORD_W-1:0]               tail_word
);
   import sse_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int OCC_W = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [OCC_W-1:0]     occ_ff, occ_in;
   logic [IDX_W-1:0]     cnt_ff, cnt_in;
   logic [WORD_W-1:0]    key_ff, key_in;
   logic [WORD_W-1:0]    repl_ff, repl_in;
   logic                 replace_ff, replace_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0]     pend_pos_ff, pend_pos_in;
   logic                 hit_ff, hit_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [WORD_W-1:0]    rsp_popped_ff, rsp_popped_in;
   logic [POS_W-1:0]     rsp_pos_ff, rsp_pos_in;
   logic [FILL_W-1:0]    rsp_fill_ff, rsp_fill_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 out_free;
   logic                 accept;
   logic [OCC_W-1:0]     cnt_ext;
   logic [OCC_W-1:0]     scan_thr;
   logic                 scan_live;
   logic [IDX_W-1:0]     scan_pos;
   logic                 is_match;
   logic                 step_ok;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign accept    = req_valid && req_ready;

   // The tail cell sees the chain from the highest cell index down, so the
   // first DEPTH minus fill level words seen are empty slots above the top.
   assign cnt_ext   = OCC_W'(cnt_ff);
   assign scan_thr  = OCC_W'(DEPTH) - occ_ff;
   assign scan_live = cnt_ext >= scan_thr;
   assign scan_pos  = IDX_W'(cnt_ext - scan_thr);
   assign is_match  = scan_live && (tail_word == key_ff);
   // A second search match needs the result register to pass on the pending one.
   assign step_ok   = (state_ff == S_SCAN) &&
                      !(is_match && !replace_ff && pend_valid_ff && !out_free);

   always_comb begin
      state_in      = state_ff;
      occ_in        = occ_ff;
      cnt_in        = cnt_ff;
      key_in        = key_ff;
      repl_in       = repl_ff;
      replace_in    = replace_ff;
      pend_valid_in = pend_valid_ff;
      pend_pos_in   = pend_pos_ff;
      hit_in        = hit_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_popped_in = rsp_popped_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_fill_in   = rsp_fill_ff;
      rsp_last_in   = rsp_last_ff;

      cmd      = '0;
      wr_idx   = IDX_W'(occ_ff - OCC_W'(1) - OCC_W'(req_position));
      wr_word  = req_new_value;
      head_in  = req_value;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_popped_in = '0;
               rsp_pos_in    = '0;
               rsp_last_in   = 1'b1;
               case (req_operation)
                  OP_PUSH: begin
                     if (occ_ff == OCC_W'(DEPTH)) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        cmd.shift_dn = 1'b1;
                        occ_in       = occ_ff + OCC_W'(1);
                     end
                  end
                  OP_POP: begin
                     if (occ_ff == '0) begin
                        rsp_status_in = ST_EMPTY;
                        rsp_popped_in = '1;
                     end else begin
                        cmd.shift_up  = 1'b1;
                        occ_in        = occ_ff - OCC_W'(1);
                        rsp_popped_in = head_word;
                     end
                  end
                  OP_SEARCH, OP_REPLACE: begin
                     rsp_valid_in  = rsp_valid_ff && !rsp_ready;
                     rsp_status_in = rsp_status_ff;
                     rsp_popped_in = rsp_popped_ff;
                     rsp_pos_in    = rsp_pos_ff;
                     rsp_last_in   = rsp_last_ff;
                     state_in      = S_SCAN;
                     cnt_in        = '0;
                     key_in        = req_value;
                     repl_in       = req_new_value;
                     replace_in    = (req_operation == OP_REPLACE);
                     pend_valid_in = 1'b0;
                     hit_in        = 1'b0;
                  end
                  OP_WRITE: begin
                     if (FILL_W'(req_position) < FILL_W'(occ_ff)) begin
                        cmd.wr_en = 1'b1;
                     end else begin
                        rsp_status_in = ST_BAD_INDEX;
                     end
                  end
                  default: begin
                     rsp_status_in = ST_OK;
                  end
               endcase
               rsp_fill_in = FILL_W'(occ_in);
            end
         end
         S_SCAN: begin
            if (step_ok) begin
               cmd.shift_dn = 1'b1;
               head_in      = (replace_ff && is_match) ? repl_ff : tail_word;
               if (is_match) begin
                  if (replace_ff) begin
                     hit_in = 1'b1;
                  end else begin
                     if (pend_valid_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_OK;
                        rsp_popped_in = '0;
                        rsp_pos_in    = POS_W'(pend_pos_ff);
                        rsp_fill_in   = FILL_W'(occ_ff);
                        rsp_last_in   = 1'b0;
                     end
                     pend_valid_in = 1'b1;
                     pend_pos_in   = scan_pos;
                  end
               end
               cnt_in = cnt_ff + IDX_W'(1);
               if (cnt_ff == IDX_W'(DEPTH - 1)) begin
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_popped_in = '0;
               rsp_fill_in   = FILL_W'(occ_ff);
               rsp_last_in   = 1'b1;
               rsp_pos_in    = '0;
               if (replace_ff) begin
                  rsp_status_in = hit_ff ? ST_OK : ST_NOT_FOUND;
               end else if (pend_valid_ff) begin
                  rsp_status_in = ST_OK;
                  rsp_pos_in    = POS_W'(pend_pos_ff);
               end else begin
                  rsp_status_in = ST_NOT_FOUND;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         occ_ff        <= '0;
         cnt_ff        <= '0;
         pend_valid_ff <= 1'b0;
         hit_ff        <= 1'b0;
         replace_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         occ_ff        <= occ_in;
         cnt_ff        <= cnt_in;
         pend_valid_ff <= pend_valid_in;
         hit_ff        <= hit_in;
         replace_ff    <= replace_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      key_ff        <= key_in;
      repl_ff       <= repl_in;
      pend_pos_ff   <= pend_pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_popped_ff <= rsp_popped_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_fill_ff   <= rsp_fill_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_popped_word    = rsp_popped_ff;
   assign rsp_match_position = rsp_pos_ff;
   assign rsp_fill_level     = rsp_fill_ff;
   assign rsp_last           = rsp_last_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(DEPTH))
      else $error("fill level above stack depth");

   a_scan_keeps_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |=> (occ_ff == $past(occ_ff)))
      else $error("fill level changed during a chain walk");

   a_one_cell_op: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.shift_dn, cmd.shift_up, cmd.wr_en}))
      else $error("conflicting cell chain commands");

   a_partial_in_walk: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (state_ff != S_IDLE))
      else $error("non-final result outside a search");

endmodule

// File: hw/rtl/searchable_stack_engine.sv
// ----------------------------------------------------------------------------
// Searchable stack engine
// Bounded stack of signed 32-bit words with push, pop, search, replace-all
// and write-at-position, built as a chain of word cells.
// ----------------------------------------------------------------------------
// The words sit in a row of DEPTH cells with the top of the stack in cell 0;
// push and pop shift the whole row by one cell at once. Push, pop,
// write-at and unused codes take one transfer in and give one registered
// result out in the next cycle, and a new request is taken once the result register is free.
// Search and replace-all rotate the whole row once through the comparator at
// the last cell, one cell per cycle unless a search match must wait for the
// result register, and then give the final result; the next request can be
// taken in the cycle that the final result is taken. A result channel stall
// while a newer search match or the final result waits holds back the walk or
// the final result. Search gives one result per match, bottom entry first,
// with last set on the highest match, or one not-found result.
module searchable_stack_engine #(
   parameter int DEPTH = sse_pkg::DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [sse_pkg::OP_W-1:0]             req_operation,
   input  logic signed [sse_pkg::WORD_W-1:0]    req_value,
   input  logic signed [sse_pkg::WORD_W-1:0]    req_new_value,
   input  logic [sse_pkg::POS_W-1:0]            req_position,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [sse_pkg::STATUS_W-1:0]         rsp_status,
   output logic signed [sse_pkg::WORD_W-1:0]    rsp_popped_word,
   output logic [sse_pkg::POS_W-1:0]            rsp_match_position,
   output logic [sse_pkg::FILL_W-1:0]           rsp_fill_level,
   output logic                                 rsp_last
);
   import sse_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);

   cell_ctrl_type       cmd;
   logic [IDX_W-1:0]    wr_idx;
   logic [WORD_W-1:0]   wr_word;
   logic [WORD_W-1:0]   head_in;
   logic [WORD_W-1:0]   cell_word [DEPTH];

   sse_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_value          (req_value),
      .req_new_value      (req_new_value),
      .req_position       (req_position),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_popped_word    (rsp_popped_word),
      .rsp_match_position (rsp_match_position),
      .rsp_fill_level     (rsp_fill_level),
      .rsp_last           (rsp_last),
      .cmd                (cmd),
      .wr_idx             (wr_idx),
      .wr_word            (wr_word),
      .head_in            (head_in),
      .head_word          (cell_word[0]),
      .tail_word          (cell_word[DEPTH-1])
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cell_ctrl_type     ctrl;
      logic [WORD_W-1:0] prev_word;
      logic [WORD_W-1:0] next_word;

      assign ctrl.shift_dn = cmd.shift_dn;
      assign ctrl.shift_up = cmd.shift_up;
      assign ctrl.wr_en    = cmd.wr_en && (wr_idx == IDX_W'(i));

      if (i == 0) begin : g_head
         assign prev_word = head_in;
      end else begin : g_body
         assign prev_word = cell_word[i-1];
      end

      // Above the top of the stack the contents do not matter.
      if (i == DEPTH - 1) begin : g_tail
         assign next_word = '0;
      end else begin : g_inner
         assign next_word = cell_word[i+1];
      end

      sse_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .prev_word (prev_word),
         .next_word (next_word),
         .wr_word   (wr_word),
         .word      (cell_word[i])
      );
   end

endmodule

// File: verif/sse_checker.sv
// ----------------------------------------------------------------------------
// Searchable stack engine checker
// Watches the request and result channels of the stack engine. It keeps its
// own copy of the stack, works out the results of each accepted request, and
// compares every accepted result field by field against the oldest one due.
// ----------------------------------------------------------------------------
module sse_checker #(
   parameter int DEPTH = sse_pkg::DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [sse_pkg::OP_W-1:0]            req_operation,
   input  logic signed [sse_pkg::WORD_W-1:0]   req_value,
   input  logic signed [sse_pkg::WORD_W-1:0]   req_new_value,
   input  logic [sse_pkg::POS_W-1:0]           req_position,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [sse_pkg::STATUS_W-1:0]        rsp_status,
   input  logic signed [sse_pkg::WORD_W-1:0]   rsp_popped_word,
   input  logic [sse_pkg::POS_W-1:0]           rsp_match_position,
   input  logic [sse_pkg::FILL_W-1:0]          rsp_fill_level,
   input  logic                                rsp_last,
   output int                                  fail_count,
   output int                                  pending,
   output int                                  checked_count,
   output int                                  full_count,
   output int                                  empty_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import sse_pkg::*;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [WORD_W-1:0]   popped_word;
      logic [POS_W-1:0]    match_position;
      logic [FILL_W-1:0]   fill_level;
      logic                last;
   } stack_answer_type;

   stack_answer_type  awaited_answers[$];
   logic [WORD_W-1:0] stack_words [DEPTH];
   int                stack_fill;

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      fail_count++;
   endtask

   function automatic stack_answer_type make_answer(input logic [STATUS_W-1:0] status,
                                                    input logic [WORD_W-1:0] word,
                                                    input logic [POS_W-1:0] pos,
                                                    input logic last);
      stack_answer_type a;
      a.status         = status;
      a.popped_word    = word;
      a.match_position = pos;
      a.fill_level     = stack_fill[FILL_W-1:0];
      a.last           = last;
      return a;
   endfunction

   task automatic predict_operation(input logic [OP_W-1:0] op,
                                    input logic [WORD_W-1:0] key,
                                    input logic [WORD_W-1:0] repl,
                                    input logic [POS_W-1:0] pos);
      int  hits;
      int  seen;
      bit  found;
      hits  = 0;
      seen  = 0;
      found = 1'b0;
      case (op)
         OP_PUSH: begin
            if (stack_fill >= DEPTH) begin
               awaited_answers.push_back(make_answer(ST_FULL, '0, '0, 1'b1));
            end else begin
               stack_words[stack_fill] = key;
               stack_fill++;
               awaited_answers.push_back(make_answer(ST_OK, '0, '0, 1'b1));
            end
         end
         OP_POP: begin
            if (stack_fill == 0) begin
               awaited_answers.push_back(make_answer(ST_EMPTY, '1, '0, 1'b1));
            end else begin
               stack_fill--;
               awaited_answers.push_back(make_answer(ST_OK, stack_words[stack_fill],
                                                     '0, 1'b1));
            end
         end
         OP_SEARCH: begin
            for (int i = 0; i < stack_fill; i++)
               if (stack_words[i] == key) hits++;
            if (hits == 0) begin
               awaited_answers.push_back(make_answer(ST_NOT_FOUND, '0, '0, 1'b1));
            end else begin
               // One result per matching position, bottom first; the highest
               // match closes the answer.
               for (int i = 0; i < stack_fill; i++) begin
                  if (stack_words[i] == key) begin
                     seen++;
                     awaited_answers.push_back(make_answer(ST_OK, '0, i[POS_W-1:0],
                                                           seen == hits));
                  end
               end
            end
         end
         OP_REPLACE: begin
            for (int i = 0; i < stack_fill; i++) begin
               if (stack_words[i] == key) begin
                  stack_words[i] = repl;
                  found = 1'b1;
               end
            end
            awaited_answers.push_back(make_answer(found ? ST_OK : ST_NOT_FOUND,
                                                  '0, '0, 1'b1));
         end
         OP_WRITE: begin
            if (int'(pos) < stack_fill) begin
               stack_words[pos] = repl;
               awaited_answers.push_back(make_answer(ST_OK, '0, '0, 1'b1));
            end else begin
               awaited_answers.push_back(make_answer(ST_BAD_INDEX, '0, '0, 1'b1));
            end
         end
         default: begin
            awaited_answers.push_back(make_answer(ST_OK, '0, '0, 1'b1));
         end
      endcase
   endtask

   task automatic check_answer();
      stack_answer_type want;
      checked_count++;
      if (awaited_answers.size() == 0) begin
         report_mismatch($sformatf("result %0d arrived with none due (status %0d)",
                                   checked_count, rsp_status));
         return;
      end
      want = awaited_answers.pop_front();
      if (want.status == ST_FULL) full_count++;
      if (want.status == ST_EMPTY) empty_count++;
      if (rsp_status !== want.status)
         report_mismatch($sformatf("result %0d: status %0d, expected %0d",
                                   checked_count, rsp_status, want.status));
      if (rsp_popped_word !== want.popped_word)
         report_mismatch($sformatf("result %0d: popped word %h, expected %h",
                                   checked_count, rsp_popped_word, want.popped_word));
      if (rsp_match_position !== want.match_position)
         report_mismatch($sformatf("result %0d: match position %0d, expected %0d",
                                   checked_count, rsp_match_position,
                                   want.match_position));
      if (rsp_fill_level !== want.fill_level)
         report_mismatch($sformatf("result %0d: fill level %0d, expected %0d",
                                   checked_count, rsp_fill_level, want.fill_level));
      if (rsp_last !== want.last)
         report_mismatch($sformatf("result %0d: last %b, expected %b",
                                   checked_count, rsp_last, want.last));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         awaited_answers.delete();
         stack_fill    = 0;
         fail_count    = 0;
         checked_count = 0;
         full_count    = 0;
         empty_count   = 0;
      end else begin
         if (req_valid && req_ready)
            predict_operation(req_operation, req_value, req_new_value, req_position);
         if (rsp_valid && rsp_ready)
            check_answer();
      end
      pending = awaited_answers.size();
   end

endmodule

// File: verif/searchable_stack_engine_test.sv
// ----------------------------------------------------------------------------
// Searchable stack engine testbench
// Drives directed corner cases and then random operation mixes into the
// stack engine, with random idle cycles on both channels and one long result
// stall that backs the engine up. The checker beside the engine predicts and
// compares every result; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module searchable_stack_engine_test;
   timeunit 1ns;
   timeprecision 1ps;
   import sse_pkg::*;

   localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;
   localparam int              HOLD_CYCLES = 250;

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [OP_W-1:0]            req_operation = OP_PUSH;
   logic signed [WORD_W-1:0]   req_value = '0;
   logic signed [WORD_W-1:0]   req_new_value = '0;
   logic [POS_W-1:0]           req_position = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [STATUS_W-1:0]        rsp_status;
   logic signed [WORD_W-1:0]   rsp_popped_word;
   logic [POS_W-1:0]           rsp_match_position;
   logic [FILL_W-1:0]          rsp_fill_level;
   logic                       rsp_last;

   int  fail_count;
   int  pending;
   int  checked_count;
   int  full_count;
   int  empty_count;
   int  op_sent [8];
   bit  calm = 1'b0;
   int  hold_asked = 0;
   int  hold_taken = 0;
   int  hold_left = 0;

   searchable_stack_engine i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_value          (req_value),
      .req_new_value      (req_new_value),
      .req_position       (req_position),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_popped_word    (rsp_popped_word),
      .rsp_match_position (rsp_match_position),
      .rsp_fill_level     (rsp_fill_level),
      .rsp_last           (rsp_last)
   );

   sse_checker i_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_value          (req_value),
      .req_new_value      (req_new_value),
      .req_position       (req_position),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_popped_word    (rsp_popped_word),
      .rsp_match_position (rsp_match_position),
      .rsp_fill_level     (rsp_fill_level),
      .rsp_last           (rsp_last),
      .fail_count         (fail_count),
      .pending            (pending),
      .checked_count      (checked_count),
      .full_count         (full_count),
      .empty_count        (empty_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Result side: random stalls, none while calm, and a long counted hold-off
   // whenever the stimulus asks for one.
   always @(posedge clock) begin
      if (hold_taken != hold_asked) begin
         hold_taken = hold_asked;
         hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(0, 99) >= 30);
      end
   end

   // Called at a rising edge; returns at the edge where the transfer happens.
   task automatic send_op(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] word,
                          input logic [WORD_W-1:0] repl, input logic [POS_W-1:0] pos);
      while (!calm && $urandom_range(0, 99) < 30) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_value     <= word;
      req_new_value <= repl;
      req_position  <= pos;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      op_sent[op]++;
   endtask

   // Mostly words from a small set so that searches and replaces hit.
   function automatic logic [WORD_W-1:0] pick_word();
      if ($urandom_range(0, 99) >= 75) return $urandom;
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         4: return 32'h0000_0001;
         5: return 32'h0000_00a5;
         6: return 32'h5a5a_5a5a;
         default: return 32'hdead_0001;
      endcase
   endfunction

   function automatic logic [POS_W-1:0] pick_position();
      if ($urandom_range(0, 1) == 0) return POS_W'($urandom_range(0, 63));
      return POS_W'($urandom_range(0, 7));
   endfunction

   function automatic logic [OP_W-1:0] pick_operation();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 30) return OP_PUSH;
      if (roll < 50) return OP_POP;
      if (roll < 70) return OP_SEARCH;
      if (roll < 82) return OP_REPLACE;
      if (roll < 95) return OP_WRITE;
      case ($urandom_range(0, 2))
         0: return OP_SPARE_A;
         1: return OP_SPARE_B;
         default: return OP_SPARE_C;
      endcase
   endfunction

   task automatic send_mixed(input int count);
      for (int n = 0; n < count; n++)
         send_op(pick_operation(), pick_word(), $urandom, pick_position());
   endtask

   initial begin
      logic [WORD_W-1:0] fill_word;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Everything on an empty stack, and the unused codes.
      send_op(OP_POP,     32'h1234_5678, 32'h0, 6'd0);
      send_op(OP_SEARCH,  32'h0000_0000, 32'h0, 6'd0);
      send_op(OP_REPLACE, 32'h0000_0000, 32'h1, 6'd0);
      send_op(OP_WRITE,   32'h0,         32'h5555_5555, 6'd0);
      send_op(OP_SPARE_A, 32'hffff_ffff, 32'hffff_ffff, 6'd63);
      send_op(OP_SPARE_B, 32'h0,         32'h0,         6'd0);
      send_op(OP_SPARE_C, 32'h8000_0000, 32'h7fff_ffff, 6'd21);
      // Extreme words, with a duplicate to give a two-match search.
      send_op(OP_PUSH,    32'h8000_0000, 32'h0, 6'd0);
      send_op(OP_PUSH,    32'h7fff_ffff, 32'h0, 6'd0);
      send_op(OP_PUSH,    32'h0000_0000, 32'h0, 6'd0);
      send_op(OP_PUSH,    32'hffff_ffff, 32'h0, 6'd0);
      send_op(OP_PUSH,    32'h7fff_ffff, 32'h0, 6'd63);
      send_op(OP_SEARCH,  32'h7fff_ffff, 32'h0, 6'd0);
      send_op(OP_SEARCH,  32'h0000_1234, 32'h0, 6'd0);
      send_op(OP_REPLACE, 32'h7fff_ffff, 32'h8000_0000, 6'd0);
      send_op(OP_REPLACE, 32'h0000_0055, 32'h0000_0066, 6'd0);
      send_op(OP_SEARCH,  32'h8000_0000, 32'h0, 6'd0);
      // Write-at on the top entry, just past it, at the highest position and on the bottom entry.
      send_op(OP_WRITE,   32'h0, 32'hffff_ffff, 6'd4);
      send_op(OP_WRITE,   32'h0, 32'h0000_0001, 6'd5);
      send_op(OP_WRITE,   32'h0, 32'h0000_0002, 6'd63);
      send_op(OP_WRITE,   32'h0, 32'h7fff_ffff, 6'd0);
      send_op(OP_POP,     32'h0, 32'h0, 6'd0);
      send_op(OP_POP,     32'h0, 32'h0, 6'd0);

      send_mixed(100);

      // Fill past full while the result side holds off, so the engine backs up.
      calm = 1'b1;
      hold_asked++;
      fill_word = $urandom;
      for (int n = 0; n < 72; n++)
         send_op(OP_PUSH, ($urandom_range(0, 1) == 0) ? fill_word : pick_word(),
                 $urandom, POS_W'($urandom_range(0, 63)));
      send_op(OP_SEARCH, fill_word, 32'h0, 6'd0);
      for (int n = 0; n < 19; n++) begin
         case ($urandom_range(0, 2))
            0: send_op(OP_SEARCH, pick_word(), $urandom, POS_W'($urandom_range(0, 63)));
            1: send_op(OP_REPLACE, pick_word(), pick_word(), POS_W'($urandom_range(0, 63)));
            default: send_op(OP_WRITE, $urandom, pick_word(), POS_W'($urandom_range(0, 63)));
         endcase
      end
      calm = 1'b0;

      // Drain toward and possibly past empty, with a search now and then.
      for (int n = 0; n < 70; n++) begin
         if ($urandom_range(0, 9) == 0)
            send_op(OP_SEARCH, pick_word(), $urandom, pick_position());
         else
            send_op(OP_POP, $urandom, $urandom, pick_position());
      end

      send_mixed(40);
      req_valid <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (DEPTH_DEF + 16) @(negedge clock);

      $display("Sent %0d pushes, %0d pops, %0d searches, %0d replaces, %0d writes, %0d spare.",
               op_sent[OP_PUSH], op_sent[OP_POP], op_sent[OP_SEARCH], op_sent[OP_REPLACE],
               op_sent[OP_WRITE], op_sent[OP_SPARE_A] + op_sent[OP_SPARE_B]
               + op_sent[OP_SPARE_C]);
      $display("Checked %0d results, %0d of them full pushes and %0d empty pops.",
               checked_count, full_count, empty_count);
      if (pending != 0)
         $display("%0d expected results never arrived.", pending);
      if (fail_count == 0 && pending == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("Timed out with %0d results outstanding.", pending);
      $display("== FAIL ==");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/sse_pkg.sv
hw/rtl/sse_cell.sv
hw/rtl/sse_ctrl.sv
hw/rtl/searchable_stack_engine.sv
verif/sse_checker.sv
verif/searchable_stack_engine_test.sv
